// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property at every clock edge, reset cycles included.
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/aptp_pkg.sv
// Shared types, constants and helpers of the alignment pair text parser.
`timescale 1ns / 1ps

package aptp_pkg;

  // Default ceiling for a parsed coordinate.
  localparam int unsigned COORD_LIMIT_DEFAULT = 1023;

  // Width of a reported coordinate.
  localparam int COORD_W = 10;

  // Result kinds.
  localparam logic [1:0] KIND_PAIR    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // Length of the " ||| " separator.
  localparam logic [2:0] SEP_LEN = 3'd5;

  // Result queue geometry.
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = PTR_W + 1;

  // One input request.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } aptp_in_t;

  // One result.
  typedef struct packed {
    logic [1:0]         result_kind;
    logic [COORD_W-1:0] coord_a;
    logic [COORD_W-1:0] coord_b;
    logic               bad_alignment;
  } aptp_out_t;

  // Results produced by one input byte, oldest in slot zero.
  typedef struct packed {
    logic [1:0] count;
    aptp_out_t  slot0;
    aptp_out_t  slot1;
  } aptp_batch_t;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_SPACE  = 4'b1000
  } aptp_phase_t;

  // Character expected at a given position of the separator.
  function automatic logic [7:0] sep_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_SPACE;
      3'd1:    c = CH_BAR;
      3'd2:    c = CH_BAR;
      3'd3:    c = CH_BAR;
      3'd4:    c = CH_SPACE;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/aptp_out_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one per cycle while out_ready is high.
`timescale 1ns / 1ps

module aptp_out_fifo import aptp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  aptp_batch_t batch,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output aptp_out_t   out_data
);

  aptp_out_t        entries [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       push_cnt;
  logic             pop;

  // Room for a full batch of two results.
  assign room      = count <= CNT_W'(OUT_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign push_cnt  = push ? batch.count : 2'd0;

  assign count_next = count + CNT_W'(push_cnt) - CNT_W'(pop);

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  // Result storage; a two-result batch fills two consecutive entries.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wr_ptr] <= batch.slot0;
    end
    if (push_cnt == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= batch.slot1;
    end
  end

endmodule

// File: rtl/core/aptp_parse.sv
// Per-byte parse logic and parser state of the alignment pair text parser.
`timescale 1ns / 1ps

module aptp_parse import aptp_pkg::*; #(
  parameter int unsigned COORD_LIMIT = COORD_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  aptp_in_t    item,
  output aptp_batch_t batch
);

  localparam int ACC_W = $clog2(COORD_LIMIT + 1);
  localparam int SUM_W = ACC_W + 4;
  localparam int EXT_W = (ACC_W > COORD_W) ? ACC_W : COORD_W;
  localparam logic [SUM_W-1:0] LIMIT_S = SUM_W'(COORD_LIMIT);
  localparam logic [ACC_W-1:0] LIMIT_A = ACC_W'(COORD_LIMIT);

  // Parser state.
  aptp_phase_t      phase;
  logic [ACC_W-1:0] first_accum;
  logic [ACC_W-1:0] second_accum;
  logic [ACC_W-1:0] largest_first;
  logic [ACC_W-1:0] largest_second;
  logic             error_latch;
  logic [2:0]       separator_progress;
  logic             line_finished;

  aptp_phase_t      phase_next;
  logic [ACC_W-1:0] first_accum_next;
  logic [ACC_W-1:0] second_accum_next;
  logic [ACC_W-1:0] largest_first_next;
  logic [ACC_W-1:0] largest_second_next;
  logic             error_latch_next;
  logic [2:0]       separator_progress_next;
  logic             line_finished_next;

  logic [7:0]       b;
  logic             fin;
  logic             is_dec;
  logic             is_eol;
  logic [3:0]       digit;
  logic [2:0]       sep_calc;
  logic [SUM_W-1:0] first_sum;
  logic [SUM_W-1:0] second_sum;
  logic             first_ovf;
  logic             second_ovf;
  logic             start_ovf;
  logic [ACC_W-1:0] first_sat;
  logic [ACC_W-1:0] second_sat;
  logic [ACC_W-1:0] start_sat;

  // Low bits of an accumulator as a reported coordinate.
  function automatic logic [COORD_W-1:0] to_coord(input logic [ACC_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[COORD_W-1:0];
  endfunction

  assign b      = item.text_byte;
  assign fin    = item.final_byte;
  assign is_dec = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_eol = (b == CH_NL) || (b == CH_CR);
  assign digit  = 4'(b - CH_ZERO);

  // Separator tracking; overlapping matches restart on a space.
  always_comb begin
    if ((separator_progress < SEP_LEN) && (b == sep_char(separator_progress))) begin
      sep_calc = separator_progress + 3'd1;
    end else begin
      sep_calc = (b == CH_SPACE) ? 3'd1 : 3'd0;
    end
  end

  // Decimal accumulation with saturation at the coordinate limit.
  assign first_sum  = SUM_W'(first_accum) * SUM_W'(10) + SUM_W'(digit);
  assign second_sum = SUM_W'(second_accum) * SUM_W'(10) + SUM_W'(digit);
  assign first_ovf  = first_sum > LIMIT_S;
  assign second_ovf = second_sum > LIMIT_S;
  assign start_ovf  = SUM_W'(digit) > LIMIT_S;
  assign first_sat  = first_ovf ? LIMIT_A : first_sum[ACC_W-1:0];
  assign second_sat = second_ovf ? LIMIT_A : second_sum[ACC_W-1:0];
  assign start_sat  = start_ovf ? LIMIT_A : ACC_W'(digit);

  // Next state and the results of the current byte.
  always_comb begin
    aptp_out_t res;
    logic      tok;
    logic      ended;

    res                     = '0;
    tok                     = 1'b0;
    ended                   = 1'b0;
    phase_next              = phase;
    first_accum_next        = first_accum;
    second_accum_next       = second_accum;
    largest_first_next      = largest_first;
    largest_second_next     = largest_second;
    error_latch_next        = error_latch;
    separator_progress_next = separator_progress;
    line_finished_next      = line_finished;
    batch                   = '0;

    if (line_finished) begin
      // Bytes after the line end are dropped until the last byte re-arms.
      if (fin) begin
        phase_next              = PH_START;
        first_accum_next        = '0;
        second_accum_next       = '0;
        largest_first_next      = '0;
        largest_second_next     = '0;
        error_latch_next        = 1'b0;
        separator_progress_next = 3'd0;
        line_finished_next      = 1'b0;
      end
    end else if (sep_calc == SEP_LEN) begin
      // Full separator: clear the parse state and announce a restart, and a summary on the last byte.
      phase_next              = PH_START;
      first_accum_next        = '0;
      second_accum_next       = '0;
      largest_first_next      = '0;
      largest_second_next     = '0;
      error_latch_next        = 1'b0;
      separator_progress_next = 3'd1;
      batch.slot0.result_kind = KIND_RESTART;
      batch.count             = 2'd1;
      if (fin) begin
        batch.slot1.result_kind = KIND_SUMMARY;
        batch.count             = 2'd2;
        separator_progress_next = 3'd0;
      end
    end else begin
      separator_progress_next = sep_calc;

      case (phase)
        PH_FIRST: begin
          if (is_dec) begin
            first_accum_next = first_sat;
            error_latch_next = error_latch | first_ovf;
          end else begin
            if (first_accum > largest_first) begin
              largest_first_next = first_accum;
            end
            error_latch_next  = error_latch | (b != CH_DASH);
            second_accum_next = '0;
            phase_next        = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (is_dec) begin
            second_accum_next = second_sat;
            error_latch_next  = error_latch | second_ovf;
          end else begin
            if (second_accum > largest_second) begin
              largest_second_next = second_accum;
            end
            batch.slot0.result_kind   = KIND_PAIR;
            batch.slot0.coord_a       = to_coord(first_accum);
            batch.slot0.coord_b       = to_coord(second_accum);
            batch.slot0.bad_alignment = error_latch;
            batch.count               = 2'd1;
            if (b == CH_SPACE) begin
              phase_next = PH_SPACE;
            end else begin
              tok = 1'b1;
            end
          end
        end
        PH_SPACE: begin
          tok = b != CH_SPACE;
        end
        default: begin
          tok = 1'b1;
        end
      endcase

      // Token start: a line end, a first digit, or a missing first number.
      if (tok) begin
        if (is_eol) begin
          ended = 1'b1;
        end else begin
          first_accum_next  = '0;
          second_accum_next = '0;
          if (is_dec) begin
            first_accum_next = start_sat;
            error_latch_next = error_latch_next | start_ovf;
            phase_next       = PH_FIRST;
          end else begin
            error_latch_next = error_latch_next | (b != CH_DASH);
            phase_next       = PH_SECOND;
          end
        end
      end

      // Last byte finishes a pending pair or flags a lone first number.
      if (!ended && fin) begin
        if (phase_next == PH_SECOND) begin
          if (second_accum_next > largest_second_next) begin
            largest_second_next = second_accum_next;
          end
          if (batch.count == 2'd0) begin
            batch.slot0.result_kind   = KIND_PAIR;
            batch.slot0.coord_a       = to_coord(first_accum_next);
            batch.slot0.coord_b       = to_coord(second_accum_next);
            batch.slot0.bad_alignment = error_latch_next;
            batch.count               = 2'd1;
          end
        end else if (phase_next == PH_FIRST) begin
          if (first_accum_next > largest_first_next) begin
            largest_first_next = first_accum_next;
          end
          error_latch_next = 1'b1;
        end
      end

      // Line summary, then a clean parser for the next line.
      if (ended || fin) begin
        res.result_kind   = KIND_SUMMARY;
        res.coord_a       = to_coord(largest_first_next);
        res.coord_b       = to_coord(largest_second_next);
        res.bad_alignment = error_latch_next;
        if (batch.count == 2'd0) begin
          batch.slot0 = res;
        end else begin
          batch.slot1 = res;
        end
        batch.count             = batch.count + 2'd1;
        phase_next              = PH_START;
        first_accum_next        = '0;
        second_accum_next       = '0;
        largest_first_next      = '0;
        largest_second_next     = '0;
        error_latch_next        = 1'b0;
        separator_progress_next = 3'd0;
        line_finished_next      = ended && !fin;
      end
    end
  end

  // State registers advance once per parsed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_START;
      first_accum        <= '0;
      second_accum       <= '0;
      largest_first      <= '0;
      largest_second     <= '0;
      error_latch        <= 1'b0;
      separator_progress <= 3'd0;
      line_finished      <= 1'b0;
    end else if (step) begin
      phase              <= phase_next;
      first_accum        <= first_accum_next;
      second_accum       <= second_accum_next;
      largest_first      <= largest_first_next;
      largest_second     <= largest_second_next;
      error_latch        <= error_latch_next;
      separator_progress <= separator_progress_next;
      line_finished      <= line_finished_next;
    end
  end

endmodule

// File: rtl/core/alignment_pair_text_parser_core.sv
// Top level of the alignment pair text parser: input register, parser and result queue.
`timescale 1ns / 1ps

// Parses a line of x-y decimal pairs one byte per request and returns pair, restart
// and end-of-line summary results. A byte is taken every cycle except while the input
// stalls. It is parsed straight out of the input register once the queue can take its
// batch, and its results land in a four-entry queue whose head drives the output. A
// byte yields up to two results (a restart or pair followed by a line summary). The
// queue drains one result per cycle while out_ready is high, and the input stalls only
// while the queue has fewer than two free entries. Coordinates saturate at COORD_LIMIT
// and are reported in their low ten bits.
module alignment_pair_text_parser_core import aptp_pkg::*; #(
  parameter int unsigned COORD_LIMIT = COORD_LIMIT_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  aptp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output aptp_out_t out_data
);

  logic        stage_valid;
  aptp_in_t    stage_item;
  logic        step;
  logic        room;
  aptp_batch_t batch;

  // A staged byte is parsed when the queue can take a full batch.
  assign step     = stage_valid && room;
  assign in_ready = !stage_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  aptp_parse #(
    .COORD_LIMIT(COORD_LIMIT)
  ) u_parse (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (stage_item),
    .batch (batch)
  );

  aptp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .batch     (batch),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/aptp_checker.sv
// Port-level checks of the alignment pair text parser and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aptp_checker import aptp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input aptp_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input aptp_out_t out_data
);

  logic kind_ok;
  logic restart_clean;

  // Result kind is one of the three defined codes.
  assign kind_ok = (out_data.result_kind == KIND_PAIR) ||
                   (out_data.result_kind == KIND_RESTART) ||
                   (out_data.result_kind == KIND_SUMMARY);

  // A restart carries no coordinates and no error.
  assign restart_clean = (out_data.coord_a == '0) && (out_data.coord_b == '0) &&
                         !out_data.bad_alignment;

  // A stalled request stays offered with the same payload.
  `ASSERT_CLK(a_in_hold, clk, rst, in_valid && !in_ready |=> in_valid && $stable(in_data), "request changed while stalled")

  // A stalled result stays offered.
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // Only the three defined result kinds leave the block.
  `ASSERT_CLK(a_kind_legal, clk, rst, out_valid |-> kind_ok, "illegal result kind")

  // A restart result is clean.
  `ASSERT_CLK(a_restart_clean, clk, rst, out_valid && out_data.result_kind == KIND_RESTART |-> restart_clean, "restart result not clean")

  // Reset empties the result queue.
  `ASSERT_CLK_ALL(a_reset_empty, clk, rst |=> !out_valid, "result offered after reset")

endmodule

bind alignment_pair_text_parser_core aptp_checker u_checker (.*);
